// File: rtl/core/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16 byte update for the response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

    localparam int HdrDepth   = 9;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] FnReadHolding = 8'h03;
    localparam logic [7:0] FnWriteSingle = 8'h06;
    localparam logic [7:0] FnWriteMulti  = 8'h10;
    localparam logic [7:0] CountParam    = 8'h02;
    localparam logic [7:0] CountEncoder  = 8'h06;

    localparam logic [3:0] LenWrite    = 4'd8;
    localparam logic [3:0] LenMinRead  = 4'd3;
    localparam logic [3:0] LenMin      = 4'd2;
    localparam logic [3:0] CountMax    = 4'd15;
    localparam logic [8:0] LenOverhead = 9'd4;

    localparam logic signed [15:0] PosScale = 16'sd10000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_FUNC = 2'd2,
        ST_CRC  = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        reply_kind;
        logic [7:0]  slave_address;
        logic [15:0] param_value;
        logic [15:0] pos_low;
        logic [15:0] pos_high;
        logic        axis_moving;
    } entry_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrc_front.sv
// ----------------------------------------------------------------------------
// mrc_front
// Byte intake: crc, byte count, header capture and frame classification.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,
    input  wire logic                s_frame_end,
    input  wire logic                q_full,
    output logic                     q_push,
    output mrc_pkg::entry_t          q_entry
);

    logic [3:0]  cnt_reg,  cnt_next;
    logic        ovf_reg,  ovf_next;
    logic [15:0] crc_reg,  crc_next;
    logic [15:0] tail_reg, tail_next;
    logic [7:0]  hdr_reg  [mrc_pkg::HdrDepth];
    logic [7:0]  hdr_next [mrc_pkg::HdrDepth];

    logic              accept;
    logic [7:0]        fn;
    logic [7:0]        bcount;
    logic [7:0]        bcount_plus;
    logic [8:0]        exp_len;
    logic              crc_ok;
    mrc_pkg::status_t  status;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && s_frame_end;

    always_comb begin
        cnt_next  = (cnt_reg == mrc_pkg::CountMax) ? cnt_reg : cnt_reg + 4'd1;
        ovf_next  = ovf_reg || (cnt_reg == mrc_pkg::CountMax);
        crc_next  = (cnt_reg >= 4'd2) ? mrc_pkg::crc_byte(crc_reg, tail_reg[15:8])
                                      : crc_reg;
        tail_next = {tail_reg[7:0], s_rx_byte};
        for (int i = 0; i < mrc_pkg::HdrDepth; i++) begin
            hdr_next[i] = (!ovf_reg && cnt_reg == 4'(i)) ? s_rx_byte : hdr_reg[i];
        end
    end

    assign fn          = hdr_next[1];
    assign bcount      = hdr_next[2];
    assign bcount_plus = bcount + 8'd1;
    assign exp_len     = mrc_pkg::LenOverhead + {1'b0, bcount_plus};
    // crc goes out low byte first
    assign crc_ok      = (crc_next[7:0] == tail_next[15:8]) &&
                         (crc_next[15:8] == tail_next[7:0]);

    always_comb begin
        status = mrc_pkg::ST_OK;
        if (cnt_next < mrc_pkg::LenMin) begin
            status = mrc_pkg::ST_LEN;
        end else if (fn == mrc_pkg::FnReadHolding) begin
            if (cnt_next == mrc_pkg::LenWrite || cnt_next < mrc_pkg::LenMinRead ||
                ovf_next || {5'd0, cnt_next} != exp_len) begin
                status = mrc_pkg::ST_LEN;
            end else if (bcount != mrc_pkg::CountParam &&
                         bcount != mrc_pkg::CountEncoder) begin
                status = mrc_pkg::ST_FUNC;
            end else if (!crc_ok) begin
                status = mrc_pkg::ST_CRC;
            end
        end else if (fn == mrc_pkg::FnWriteSingle || fn == mrc_pkg::FnWriteMulti) begin
            if (cnt_next != mrc_pkg::LenWrite || ovf_next) begin
                status = mrc_pkg::ST_LEN;
            end else begin
                status = mrc_pkg::ST_FUNC;
            end
        end else begin
            status = mrc_pkg::ST_LEN;
        end
    end

    always_comb begin
        q_entry               = '0;
        q_entry.status        = status;
        q_entry.slave_address = hdr_next[0];
        if (status == mrc_pkg::ST_OK) begin
            if (bcount == mrc_pkg::CountParam) begin
                q_entry.param_value = {hdr_next[3], hdr_next[4]};
            end else begin
                q_entry.reply_kind  = 1'b1;
                q_entry.pos_low     = {hdr_next[5], hdr_next[6]};
                q_entry.pos_high    = {hdr_next[7], hdr_next[8]};
                q_entry.axis_moving = hdr_next[4][3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            crc_reg  <= mrc_pkg::CrcInit;
            tail_reg <= '0;
        end else if (accept) begin
            if (s_frame_end) begin
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
                crc_reg  <= mrc_pkg::CrcInit;
                tail_reg <= '0;
            end else begin
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
                crc_reg  <= crc_next;
                tail_reg <= tail_next;
            end
        end
    end

    // header bytes hold whatever was last written
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < mrc_pkg::HdrDepth; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mrc_queue.sv
// ----------------------------------------------------------------------------
// mrc_queue
// Small fifo of classified frames between intake and result stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire mrc_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output mrc_pkg::entry_t       pop_entry,
    output logic                  empty
);

    mrc_pkg::entry_t                 mem_reg [mrc_pkg::QueueDepth];
    logic [mrc_pkg::QueuePtrW-1:0]   wr_ptr_reg;
    logic [mrc_pkg::QueuePtrW-1:0]   rd_ptr_reg;
    logic [mrc_pkg::QueueCntW-1:0]   count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == mrc_pkg::QueueCntW'(mrc_pkg::QueueDepth));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mrc_back.sv
// ----------------------------------------------------------------------------
// mrc_back
// Result stages: position scaling multiply, final add and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  wire mrc_pkg::entry_t     q_entry,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic                     m_reply_kind,
    output logic [7:0]               m_slave_address,
    output logic signed [15:0]       m_param_value,
    output logic signed [29:0]       m_axis_position,
    output logic                     m_axis_moving
);

    logic                    a_valid_reg;
    mrc_pkg::entry_t         a_entry_reg;
    logic signed [29:0]      a_prod_reg;
    logic                    out_valid_reg;
    mrc_pkg::entry_t         out_entry_reg;
    logic signed [29:0]      out_pos_reg;

    logic                    a_ready;
    logic                    out_ready;
    logic signed [31:0]      prod_full;
    logic signed [29:0]      pos_next;

    assign out_ready = !out_valid_reg || m_ready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign q_pop     = !q_empty && a_ready;

    assign prod_full = $signed(q_entry.pos_high) * mrc_pkg::PosScale;
    assign pos_next  = a_prod_reg +
                       $signed({{14{a_entry_reg.pos_low[15]}}, a_entry_reg.pos_low});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= q_pop;
            end
            if (out_ready) begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_entry_reg <= q_entry;
            a_prod_reg  <= prod_full[29:0];
        end
        if (out_ready && a_valid_reg) begin
            out_entry_reg <= a_entry_reg;
            out_pos_reg   <= pos_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_entry_reg.status;
    assign m_reply_kind    = out_entry_reg.reply_kind;
    assign m_slave_address = out_entry_reg.slave_address;
    assign m_param_value   = $signed(out_entry_reg.param_value);
    assign m_axis_position = out_pos_reg;
    assign m_axis_moving   = out_entry_reg.axis_moving;

endmodule

`default_nettype wire

// File: rtl/core/modbus_rtu_response_checker.sv
// one received byte per cycle; s_ready drops only while the frame queue is full
// a result passes from the frame queue through the multiply register to the output register
// crc and frame checks finish in the byte cycle; the position multiply takes one stage
// reset: synchronous, active low; clears byte count, crc (to ffff), tail, queue
// and result stages; captured header bytes are kept until overwritten
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks Modbus RTU response frames and decodes parameter and encoder replies.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,
    input  wire logic                s_frame_end,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic                     m_reply_kind,
    output logic [7:0]               m_slave_address,
    output logic signed [15:0]       m_param_value,
    output logic signed [29:0]       m_axis_position,
    output logic                     m_axis_moving
);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    mrc_pkg::entry_t  push_entry;
    mrc_pkg::entry_t  pop_entry;

    mrc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    mrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    mrc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_reply_kind    (m_reply_kind),
        .m_slave_address (m_slave_address),
        .m_param_value   (m_param_value),
        .m_axis_position (m_axis_position),
        .m_axis_moving   (m_axis_moving)
    );

endmodule

`default_nettype wire

// File: rtl/core/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level assertions for the response checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [1:0]          m_status,
    input wire logic                m_reply_kind,
    input wire logic signed [15:0]  m_param_value,
    input wire logic signed [29:0]  m_axis_position,
    input wire logic                m_axis_moving
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
                                $stable(m_axis_position) && $stable(m_param_value))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mrc_pkg::ST_OK |->
            !m_reply_kind && m_param_value == 16'sd0 &&
            m_axis_position == 30'sd0 && !m_axis_moving)
        else $error("failed frame carries decoded fields");

    a_param_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reply_kind |-> m_axis_position == 30'sd0 && !m_axis_moving)
        else $error("parameter reply carries encoder fields");

    a_encoder_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind |-> m_param_value == 16'sd0)
        else $error("encoder reply carries parameter value");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_reply_kind    (m_reply_kind),
    .m_param_value   (m_param_value),
    .m_axis_position (m_axis_position),
    .m_axis_moving   (m_axis_moving)
);

`default_nettype wire
